// File: hw/rtl/tce_pkg.sv
// Shared types and constants for the toy CPU execute unit.
// Used by tce_div and toy_cpu_execute_unit; no dependencies.
package tce_pkg;

  typedef struct packed {
    logic [31:0] instr;
    logic [11:0] pc;
  } in_item_t;

  typedef struct packed {
    logic [11:0] next_pc;
    logic        halted;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusIllegal = 2'd1;
  localparam logic [1:0] StatusDivZero = 2'd2;
  localparam logic [1:0] StatusBadReg  = 2'd3;

  localparam logic [4:0] RegAcc   = 5'd25;
  localparam logic [4:0] RegSp    = 5'd27;
  localparam logic [4:0] RegFp    = 5'd28;
  localparam logic [4:0] RegFlags = 5'd31;
  localparam int unsigned RegCount = 32;
  localparam logic [11:0] RegLimit = 12'd32;

  localparam logic [12:0] ProgLenReset = 13'd4096;
  localparam logic [2:0]  AddrProgLen  = 3'd0;

  localparam logic [31:0] WordStart = 32'd0;
  localparam logic [31:0] WordHalt  = 32'd2;
  localparam logic [31:0] WordRet   = 32'd3;

  localparam logic [1:0] FmtZero = 2'd0;
  localparam logic [1:0] FmtOne  = 2'd1;
  localparam logic [1:0] FmtTwo  = 2'd2;

  localparam logic [1:0] SubJump   = 2'd0;
  localparam logic [1:0] SubUnary  = 2'd1;
  localparam logic [1:0] SubAluImm = 2'd0;
  localparam logic [1:0] SubStore  = 2'd1;
  localparam logic [1:0] SubLoad   = 2'd2;
  localparam logic [1:0] SubAluReg = 2'd3;

  localparam logic [15:0] OpJz    = 16'd0;
  localparam logic [15:0] OpJnz   = 16'd1;
  localparam logic [15:0] OpJmp   = 16'd2;
  localparam logic [15:0] OpCall  = 16'd3;
  localparam logic [15:0] OpSubr  = 16'd4;
  localparam logic [15:0] OpPushA = 16'd5;
  localparam logic [15:0] OpJgt   = 16'd7;
  localparam logic [15:0] OpJlt   = 16'd8;

  localparam logic [19:0] UnInc  = 20'd0;
  localparam logic [19:0] UnDec  = 20'd1;
  localparam logic [19:0] UnNot  = 20'd2;
  localparam logic [19:0] UnPush = 20'd3;
  localparam logic [19:0] UnPop  = 20'd4;

  localparam logic [3:0] AluMov = 4'd0;
  localparam logic [3:0] AluAdd = 4'd1;
  localparam logic [3:0] AluSub = 4'd2;
  localparam logic [3:0] AluMul = 4'd3;
  localparam logic [3:0] AluDiv = 4'd4;
  localparam logic [3:0] AluMod = 4'd5;
  localparam logic [3:0] AluAnd = 4'd6;
  localparam logic [3:0] AluOr  = 4'd7;
  localparam logic [3:0] AluXor = 4'd8;
  localparam logic [3:0] AluCmp = 4'd9;

  localparam logic [11:0] OpStm = 12'd10;
  localparam logic [11:0] OpLdm = 12'd11;

endpackage

// File: hw/rtl/tce_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tce_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/tce_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on tce_pkg.
module tce_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         dividend_i,
  input  logic [31:0]         divisor_i,
  output logic [31:0]         quo_o,
  output logic [31:0]         rem_o,
  output tce_pkg::div_stat_t  stat_o
);

  logic [31:0] rem_q, quo_q, dvs_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q, qneg_q, rneg_q;
  logic [32:0] shifted, diff;

  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
      dvs_q  <= divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
      qneg_q <= dividend_i[31] ^ divisor_i[31];
      rneg_q <= dividend_i[31];
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign quo_o       = qneg_q ? (32'd0 - quo_q) : quo_q;
  assign rem_o       = rneg_q ? (32'd0 - rem_q) : rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: hw/rtl/toy_cpu_execute_unit.sv
// Execute unit of a small 32-bit CPU: sequencer, register file, data memory.
// Depends on tce_pkg, tce_ram and tce_div.
//
// Usage: the input channel carries one instruction word and its program
// index per item; the output channel returns one item per input with the
// next index, a halt flag and a status code. program_length is written over
// the APB port at address 0; the user must do so only while the unit is idle,
// which the unit itself does not enforce. Each item walks a fixed sequence
// on the single register-file port and the single data-memory port: accept,
// register reads, memory reads, write-back and result. Divide and modulo
// add a pass through the serial divider before write-back. An index at or
// beyond program_length skips the work. After reset the data memory is
// swept to zero with in_stall_o high; the register file reads as reset
// until first written. A result waits in the output register while
// out_stall_i is high; the unit accepts no new item until that result
// has left the sequencer.
module toy_cpu_execute_unit #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tce_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tce_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RREG, S_MEM, S_DIV, S_WB, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    WbNone, WbAlu, WbUnary, WbPop, WbPush, WbCall, WbRet, WbSta, WbStm, WbLoad
  } wb_e;

  state_e             state_q;
  logic [2:0]         cnt_q;
  logic [AW-1:0]      clr_q;
  logic [12:0]        plen_q;
  tce_pkg::in_item_t  in_q;
  tce_pkg::out_item_t out_q;
  logic               out_valid_q;
  logic [31:0]        flags_q, sp_q, fp_q, ra_q, rb_q, m0_q, m1_q;
  logic [31:0]        rf_vld_q;
  logic [4:0]         rd_idx_q;

  logic          rf_we, mem_we;
  logic [4:0]    rf_waddr, rf_raddr;
  logic [31:0]   rf_wdata, rf_rdata, rf_val;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;

  logic               div_start;
  logic [31:0]        div_quo, div_rem;
  tce_pkg::div_stat_t div_stat;

  // decode
  logic [1:0]  fmt, sub, status_c;
  logic [31:0] instr;
  logic [12:0] next_c, next_f, pc_inc;
  logic        halt_c, oor_c, need_div, load_out;
  logic [4:0]  idx_a, idx_b, alu_dst;
  logic [3:0]  alu_op;
  logic [31:0] alu_b, alu_res, un_res;
  logic [1:0]  cmp_code;
  logic [AW-1:0] ma0, ma1;
  wb_e         wb_cls;
  logic [63:0] prod;

  assign instr  = in_q.instr;
  assign fmt    = instr[31:30];
  assign sub    = instr[29:28];
  assign pc_inc = {1'b0, in_q.pc} + 13'd1;
  assign oor_c  = {1'b0, in_q.pc} >= plen_q;
  assign prod   = ra_q * alu_b;

  always_comb begin
    status_c = tce_pkg::StatusOk;
    next_c   = pc_inc;
    halt_c   = 1'b0;
    idx_a    = instr[4:0];
    idx_b    = instr[4:0];
    alu_op   = instr[27:24];
    alu_b    = {16'd0, instr[15:0]};
    alu_dst  = instr[20:16];
    wb_cls   = WbNone;
    ma0      = AW'(sp_q - 32'd1);
    ma1      = AW'(sp_q - 32'd2);
    case (fmt)
      tce_pkg::FmtZero: begin
        if (instr == tce_pkg::WordHalt) begin
          halt_c = 1'b1;
          next_c = {1'b0, in_q.pc};
        end else if (instr == tce_pkg::WordRet) begin
          wb_cls = WbRet;
          next_c = {1'b0, m0_q[11:0] + 12'd1};
        end else if (instr != tce_pkg::WordStart) begin
          status_c = tce_pkg::StatusIllegal;
        end
      end
      tce_pkg::FmtOne: begin
        if (sub == tce_pkg::SubJump) begin
          case (instr[27:12])
            tce_pkg::OpJz:    if (flags_q[0]) next_c = {1'b0, instr[11:0]};
            tce_pkg::OpJnz:   if (!flags_q[0]) next_c = {1'b0, instr[11:0]};
            tce_pkg::OpJmp:   next_c = {1'b0, instr[11:0]};
            tce_pkg::OpCall: begin
              next_c = {1'b0, instr[11:0]};
              wb_cls = WbCall;
            end
            tce_pkg::OpSubr:  next_c = pc_inc;
            tce_pkg::OpPushA: begin
              if (instr[11:0] >= tce_pkg::RegLimit) status_c = tce_pkg::StatusBadReg;
              wb_cls = WbPush;
            end
            tce_pkg::OpJgt:   if (flags_q[1:0] == 2'd0) next_c = {1'b0, instr[11:0]};
            tce_pkg::OpJlt:   if (flags_q[1:0] == 2'd2) next_c = {1'b0, instr[11:0]};
            default:          status_c = tce_pkg::StatusIllegal;
          endcase
        end else if (sub == tce_pkg::SubUnary) begin
          if (instr[27:8] > tce_pkg::UnPop) begin
            status_c = tce_pkg::StatusIllegal;
          end else if ({4'd0, instr[7:0]} >= tce_pkg::RegLimit) begin
            status_c = tce_pkg::StatusBadReg;
          end
          case (instr[27:8])
            tce_pkg::UnPush: wb_cls = WbPush;
            tce_pkg::UnPop:  wb_cls = WbPop;
            default:         wb_cls = WbUnary;
          endcase
        end else begin
          status_c = tce_pkg::StatusIllegal;
        end
      end
      tce_pkg::FmtTwo: begin
        case (sub)
          tce_pkg::SubAluImm: begin
            idx_a = instr[20:16];
            if (instr[27:24] > tce_pkg::AluCmp) begin
              status_c = tce_pkg::StatusIllegal;
            end else if ({4'd0, instr[23:16]} >= tce_pkg::RegLimit) begin
              status_c = tce_pkg::StatusBadReg;
            end
            wb_cls = WbAlu;
          end
          tce_pkg::SubStore: begin
            if ({4'd0, instr[7:0]} >= tce_pkg::RegLimit) status_c = tce_pkg::StatusBadReg;
            wb_cls = WbSta;
          end
          tce_pkg::SubLoad: begin
            idx_a = instr[16:12];
            ma0   = AW'({20'd0, instr[11:0]});
            if ({4'd0, instr[19:12]} >= tce_pkg::RegLimit) status_c = tce_pkg::StatusBadReg;
            wb_cls = WbLoad;
          end
          default: begin
            idx_a   = instr[12:8];
            alu_op  = instr[19:16];
            alu_b   = rb_q;
            alu_dst = instr[12:8];
            ma0     = AW'(rb_q);
            if (instr[27:16] > tce_pkg::OpLdm) begin
              status_c = tce_pkg::StatusIllegal;
            end else if ({4'd0, instr[15:8]} >= tce_pkg::RegLimit ||
                         {4'd0, instr[7:0]} >= tce_pkg::RegLimit) begin
              status_c = tce_pkg::StatusBadReg;
            end
            if (instr[27:16] == tce_pkg::OpStm) begin
              wb_cls = WbStm;
            end else if (instr[27:16] == tce_pkg::OpLdm) begin
              wb_cls = WbLoad;
            end else begin
              wb_cls = WbAlu;
            end
          end
        endcase
        if (wb_cls == WbAlu && status_c == tce_pkg::StatusOk &&
            (alu_op == tce_pkg::AluDiv || alu_op == tce_pkg::AluMod) && alu_b == 32'd0) begin
          status_c = tce_pkg::StatusDivZero;
        end
      end
      default: status_c = tce_pkg::StatusIllegal;
    endcase
  end

  assign need_div = wb_cls == WbAlu && status_c == tce_pkg::StatusOk &&
                    (alu_op == tce_pkg::AluDiv || alu_op == tce_pkg::AluMod);

  always_comb begin
    if ($signed(ra_q) == $signed(alu_b)) begin
      cmp_code = 2'd1;
    end else if ($signed(ra_q) > $signed(alu_b)) begin
      cmp_code = 2'd0;
    end else begin
      cmp_code = 2'd2;
    end
    case (alu_op)
      tce_pkg::AluMov: alu_res = alu_b;
      tce_pkg::AluAdd: alu_res = ra_q + alu_b;
      tce_pkg::AluSub: alu_res = ra_q - alu_b;
      tce_pkg::AluMul: alu_res = prod[31:0];
      tce_pkg::AluDiv: alu_res = div_quo;
      tce_pkg::AluMod: alu_res = div_rem;
      tce_pkg::AluAnd: alu_res = ra_q & alu_b;
      tce_pkg::AluOr:  alu_res = ra_q | alu_b;
      tce_pkg::AluXor: alu_res = ra_q ^ alu_b;
      default:         alu_res = {flags_q[31:2], cmp_code};
    endcase
    case (instr[27:8])
      tce_pkg::UnInc: un_res = ra_q + 32'd1;
      tce_pkg::UnDec: un_res = ra_q - 32'd1;
      default:        un_res = ~ra_q;
    endcase
  end

  // write-back steps and port control
  always_comb begin
    rf_we     = 1'b0;
    rf_waddr  = idx_a;
    rf_wdata  = un_res;
    mem_we    = 1'b0;
    mem_waddr = AW'(sp_q);
    mem_wdata = ra_q;
    case (cnt_q)
      3'd0:    rf_raddr = tce_pkg::RegFlags;
      3'd1:    rf_raddr = tce_pkg::RegSp;
      3'd2:    rf_raddr = tce_pkg::RegFp;
      3'd3:    rf_raddr = idx_a;
      default: rf_raddr = idx_b;
    endcase
    mem_raddr = (cnt_q == 3'd0) ? ma0 : ma1;
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == S_WB && status_c == tce_pkg::StatusOk) begin
      case (wb_cls)
        WbAlu: begin
          rf_we    = (cnt_q == 3'd0);
          rf_waddr = (alu_op == tce_pkg::AluCmp) ? tce_pkg::RegFlags : alu_dst;
          rf_wdata = alu_res;
        end
        WbUnary: rf_we = (cnt_q == 3'd0);
        WbLoad: begin
          rf_we    = (cnt_q == 3'd0);
          rf_wdata = m0_q;
        end
        WbPop: begin
          rf_we = (cnt_q == 3'd0) || (cnt_q == 3'd1);
          if (cnt_q == 3'd0) begin
            rf_wdata = m0_q;
          end else begin
            rf_waddr = tce_pkg::RegSp;
            rf_wdata = ((idx_a == tce_pkg::RegSp) ? m0_q : sp_q) - 32'd1;
          end
        end
        WbPush: begin
          mem_we   = (cnt_q == 3'd0);
          rf_we    = (cnt_q == 3'd0);
          rf_waddr = tce_pkg::RegSp;
          rf_wdata = sp_q + 32'd1;
        end
        WbCall: begin
          mem_we   = (cnt_q == 3'd0) || (cnt_q == 3'd1);
          rf_we    = (cnt_q == 3'd0);
          rf_waddr = tce_pkg::RegSp;
          rf_wdata = sp_q + 32'd2;
          if (cnt_q == 3'd0) begin
            mem_wdata = fp_q;
          end else begin
            mem_waddr = AW'(sp_q + 32'd1);
            mem_wdata = {20'd0, in_q.pc};
          end
        end
        WbRet: begin
          rf_we = 1'b1;
          case (cnt_q)
            3'd0: begin
              rf_waddr = tce_pkg::RegAcc;
              rf_wdata = sp_q;
            end
            3'd1: begin
              rf_waddr = tce_pkg::RegSp;
              rf_wdata = fp_q;
            end
            default: begin
              rf_waddr = tce_pkg::RegFp;
              rf_wdata = m1_q;
            end
          endcase
        end
        WbSta: begin
          mem_we    = (cnt_q == 3'd0);
          mem_waddr = AW'({20'd0, instr[19:8]});
        end
        WbStm: begin
          mem_we    = (cnt_q == 3'd0);
          mem_waddr = AW'(ra_q);
          mem_wdata = rb_q;
        end
        default: ;
      endcase
    end
  end

  assign rf_val = rf_vld_q[rd_idx_q] ? rf_rdata :
                  {31'd0, rd_idx_q == tce_pkg::RegSp};

  assign div_start = (state_q == S_MEM) && (cnt_q == 3'd2) && need_div;
  assign next_f    = (status_c != tce_pkg::StatusOk) ? pc_inc : next_c;
  assign load_out  = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  tce_ram #(.Width(32), .Depth(tce_pkg::RegCount)) u_regs (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(rf_raddr), .rdata_o(rf_rdata)
  );

  tce_ram #(.Width(32), .Depth(MEM_WORDS)) u_dmem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );

  tce_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(ra_q), .divisor_i(alu_b),
    .quo_o(div_quo), .rem_o(div_rem), .stat_o(div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      clr_q       <= '0;
      plen_q      <= tce_pkg::ProgLenReset;
      out_valid_q <= 1'b0;
      rf_vld_q    <= '0;
    end else begin
      if (psel && penable && pwrite && paddr == tce_pkg::AddrProgLen) begin
        plen_q <= pwdata[12:0];
      end
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MEM_WORDS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          cnt_q <= '0;
          if (in_valid_i) state_q <= S_RREG;
        end
        S_RREG: begin
          if (oor_c) begin
            state_q <= S_DONE;
          end else if (cnt_q == 3'd5) begin
            cnt_q   <= '0;
            state_q <= S_MEM;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        S_MEM: begin
          if (cnt_q == 3'd2) begin
            cnt_q   <= '0;
            state_q <= need_div ? S_DIV : S_WB;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        S_DIV: if (div_stat.done) state_q <= S_WB;
        S_WB: begin
          if (cnt_q == 3'd2) begin
            state_q <= S_DONE;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rf_raddr;
    if (state_q == S_IDLE && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (state_q == S_RREG) begin
      case (cnt_q)
        3'd1:    flags_q <= rf_val;
        3'd2:    sp_q    <= rf_val;
        3'd3:    fp_q    <= rf_val;
        3'd4:    ra_q    <= rf_val;
        3'd5:    rb_q    <= rf_val;
        default: ;
      endcase
    end
    if (state_q == S_MEM && cnt_q == 3'd1) m0_q <= mem_rdata;
    if (state_q == S_MEM && cnt_q == 3'd2) m1_q <= mem_rdata;
    if (load_out) begin
      if (oor_c) begin
        out_q.next_pc <= in_q.pc;
        out_q.halted  <= 1'b1;
        out_q.status  <= tce_pkg::StatusOk;
      end else begin
        out_q.next_pc <= next_f[11:0];
        out_q.halted  <= (status_c == tce_pkg::StatusOk && halt_c) || next_f >= plen_q;
        out_q.status  <= status_c;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr == tce_pkg::AddrProgLen) ? {19'd0, plen_q} : 32'd0;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("unit ready right after accepting an item");

  a_no_rf_write_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RREG) |-> !rf_we)
    else $error("register file written during operand read");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (!div_stat.busy && alu_b != 32'd0))
    else $error("divider started while busy or with zero divisor");

  a_clear_writes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (mem_we && mem_wdata == 32'd0 && in_stall_o))
    else $error("memory sweep not writing zero");
`endif

endmodule

// File: sim/tb_toy_cpu_execute_unit.sv
// Self-checking testbench for toy_cpu_execute_unit: drives instruction items, predicts
// next index, halt and status from a private register file and memory copy.
// Depends on tce_pkg and the execute unit RTL only.
`timescale 1ns / 1ps

module tb_toy_cpu_execute_unit;

  localparam int unsigned CycleLimit = 600000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  tce_pkg::in_item_t   in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  tce_pkg::out_item_t  out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  toy_cpu_execute_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  logic [31:0] cpu_regs [tce_pkg::RegCount];
  logic [31:0] cpu_mem [4096];
  logic [12:0] prog_len;

  tce_pkg::in_item_t  instr_q [$];
  tce_pkg::out_item_t expected_q [$];
  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 73;
  logic        in_taken = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_status [4] = '{0, 0, 0, 0};
  int unsigned n_halts = 0;
  int unsigned cycles = 0;

  task automatic report_mismatch(input string what, input int unsigned got, input int unsigned exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    mismatches++;
  endtask

  function automatic void push_word(input logic [31:0] v);
    cpu_mem[cpu_regs[tce_pkg::RegSp][11:0]] = v;
    cpu_regs[tce_pkg::RegSp] = cpu_regs[tce_pkg::RegSp] + 1;
  endfunction

  function automatic logic [1:0] alu_exec(input logic [3:0] op, input int unsigned d,
                                          input logic [31:0] b);
    logic [31:0] a;
    logic [1:0]  code;
    a = cpu_regs[d];
    case (op)
      tce_pkg::AluMov: cpu_regs[d] = b;
      tce_pkg::AluAdd: cpu_regs[d] = a + b;
      tce_pkg::AluSub: cpu_regs[d] = a - b;
      tce_pkg::AluMul: cpu_regs[d] = a * b;
      tce_pkg::AluDiv, tce_pkg::AluMod: begin
        if (b == 0) return tce_pkg::StatusDivZero;
        if (a == 32'h8000_0000 && b == 32'hffff_ffff)
          cpu_regs[d] = (op == tce_pkg::AluDiv) ? a : 32'd0;
        else if (op == tce_pkg::AluDiv)
          cpu_regs[d] = $signed(a) / $signed(b);
        else
          cpu_regs[d] = $signed(a) % $signed(b);
      end
      tce_pkg::AluAnd: cpu_regs[d] = a & b;
      tce_pkg::AluOr:  cpu_regs[d] = a | b;
      tce_pkg::AluXor: cpu_regs[d] = a ^ b;
      default: begin
        code = ($signed(a) == $signed(b)) ? 2'd1 : (($signed(a) > $signed(b)) ? 2'd0 : 2'd2);
        cpu_regs[tce_pkg::RegFlags] = {cpu_regs[tce_pkg::RegFlags][31:2], code};
      end
    endcase
    return tce_pkg::StatusOk;
  endfunction

  function automatic tce_pkg::out_item_t execute_instr(input tce_pkg::in_item_t it);
    logic [31:0] w;
    logic [31:0] ret;
    logic [12:0] nxt;
    logic [1:0]  st;
    logic [1:0]  fl;
    logic        hlt;
    logic [11:0] a;
    int unsigned r;
    int unsigned s;
    w = it.instr;
    nxt = {1'b0, it.pc} + 13'd1;
    st = tce_pkg::StatusOk;
    hlt = 1'b0;
    fl = cpu_regs[tce_pkg::RegFlags][1:0];
    if ({1'b0, it.pc} >= prog_len)
      return '{next_pc: it.pc, halted: 1'b1, status: tce_pkg::StatusOk};
    if (w[31:30] == tce_pkg::FmtZero) begin
      if (w == tce_pkg::WordHalt) begin
        hlt = 1'b1;
        nxt = {1'b0, it.pc};
      end else if (w == tce_pkg::WordRet) begin
        ret = cpu_mem[12'(cpu_regs[tce_pkg::RegSp] - 1)];
        cpu_regs[tce_pkg::RegAcc] = cpu_regs[tce_pkg::RegSp];
        cpu_regs[tce_pkg::RegSp] = cpu_regs[tce_pkg::RegFp];
        cpu_regs[tce_pkg::RegFp] = cpu_mem[12'(cpu_regs[tce_pkg::RegAcc] - 2)];
        nxt = {1'b0, 12'(ret + 1)};
      end else if (w != tce_pkg::WordStart) begin
        st = tce_pkg::StatusIllegal;
      end
    end else if (w[31:30] == tce_pkg::FmtOne && w[29:28] == tce_pkg::SubJump) begin
      a = w[11:0];
      case (w[27:12])
        tce_pkg::OpJz:  if (fl[0]) nxt = {1'b0, a};
        tce_pkg::OpJnz: if (!fl[0]) nxt = {1'b0, a};
        tce_pkg::OpJmp: nxt = {1'b0, a};
        tce_pkg::OpCall: begin
          push_word(cpu_regs[tce_pkg::RegFp]);
          push_word({20'd0, it.pc});
          nxt = {1'b0, a};
        end
        tce_pkg::OpSubr: ;
        tce_pkg::OpPushA:
          if (a >= tce_pkg::RegLimit) st = tce_pkg::StatusBadReg;
          else push_word(cpu_regs[a]);
        tce_pkg::OpJgt: if (fl == 2'd0) nxt = {1'b0, a};
        tce_pkg::OpJlt: if (fl == 2'd2) nxt = {1'b0, a};
        default: st = tce_pkg::StatusIllegal;
      endcase
    end else if (w[31:30] == tce_pkg::FmtOne && w[29:28] == tce_pkg::SubUnary) begin
      r = w[7:0];
      if (w[27:8] > tce_pkg::UnPop) st = tce_pkg::StatusIllegal;
      else if (r >= tce_pkg::RegCount) st = tce_pkg::StatusBadReg;
      else case (w[27:8])
        tce_pkg::UnInc: cpu_regs[r] = cpu_regs[r] + 1;
        tce_pkg::UnDec: cpu_regs[r] = cpu_regs[r] - 1;
        tce_pkg::UnNot: cpu_regs[r] = ~cpu_regs[r];
        tce_pkg::UnPush: push_word(cpu_regs[r]);
        default: begin
          cpu_regs[r] = cpu_mem[12'(cpu_regs[tce_pkg::RegSp] - 1)];
          cpu_regs[tce_pkg::RegSp] = cpu_regs[tce_pkg::RegSp] - 1;
        end
      endcase
    end else if (w[31:30] == tce_pkg::FmtTwo && w[29:28] == tce_pkg::SubAluImm) begin
      r = w[23:16];
      if (w[27:24] > tce_pkg::AluCmp) st = tce_pkg::StatusIllegal;
      else if (r >= tce_pkg::RegCount) st = tce_pkg::StatusBadReg;
      else st = alu_exec(w[27:24], r, {16'd0, w[15:0]});
    end else if (w[31:30] == tce_pkg::FmtTwo && w[29:28] == tce_pkg::SubStore) begin
      r = w[7:0];
      if (r >= tce_pkg::RegCount) st = tce_pkg::StatusBadReg;
      else cpu_mem[w[19:8]] = cpu_regs[r];
    end else if (w[31:30] == tce_pkg::FmtTwo && w[29:28] == tce_pkg::SubLoad) begin
      r = w[19:12];
      if (r >= tce_pkg::RegCount) st = tce_pkg::StatusBadReg;
      else cpu_regs[r] = cpu_mem[w[11:0]];
    end else if (w[31:30] == tce_pkg::FmtTwo) begin
      r = w[15:8];
      s = w[7:0];
      if (w[27:16] > tce_pkg::OpLdm) st = tce_pkg::StatusIllegal;
      else if (r >= tce_pkg::RegCount || s >= tce_pkg::RegCount) st = tce_pkg::StatusBadReg;
      else if (w[27:16] == tce_pkg::OpStm) cpu_mem[cpu_regs[r][11:0]] = cpu_regs[s];
      else if (w[27:16] == tce_pkg::OpLdm) cpu_regs[r] = cpu_mem[cpu_regs[s][11:0]];
      else st = alu_exec(w[19:16], r, cpu_regs[s]);
    end else begin
      st = tce_pkg::StatusIllegal;
    end
    if (st != tce_pkg::StatusOk) begin
      nxt = {1'b0, it.pc} + 13'd1;
      hlt = 1'b0;
    end
    if (!hlt && nxt >= prog_len) hlt = 1'b1;
    return '{next_pc: nxt[11:0], halted: hlt, status: st};
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_q.push_back(execute_instr(in_data_i));
      n_items++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected item", out_data_o, 0);
      end else begin
        if (out_data_o.next_pc != expected_q[0].next_pc)
          report_mismatch("next_pc", out_data_o.next_pc, expected_q[0].next_pc);
        if (out_data_o.halted != expected_q[0].halted)
          report_mismatch("halted", out_data_o.halted, expected_q[0].halted);
        if (out_data_o.status != expected_q[0].status)
          report_mismatch("status", out_data_o.status, expected_q[0].status);
        n_status[expected_q[0].status]++;
        n_halts += expected_q[0].halted;
        void'(expected_q.pop_front());
      end
      n_results++;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (instr_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_i <= instr_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cnt <= 400;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
    out_stall_i <= (hold_cnt > 1) || ($urandom_range(99) < recv_idle_pct);
  end

  task automatic drain();
    wait (instr_q.size() == 0 && !in_valid_i && expected_q.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_prog_len(input logic [12:0] len);
    drain();
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= tce_pkg::AddrProgLen;
    pwdata <= {19'd0, len};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    prog_len = len;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [7:0] pick_reg();
    return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(31));
  endfunction

  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(11))
      0: w = {tce_pkg::FmtTwo, tce_pkg::SubAluImm, 4'($urandom_range(tce_pkg::AluCmp)),
              pick_reg(), 16'($urandom)};
      1: w = {tce_pkg::FmtTwo, tce_pkg::SubAluImm, 4'($urandom_range(tce_pkg::AluMov)),
              pick_reg(), 16'($urandom_range(3))};
      2: w = {tce_pkg::FmtTwo, tce_pkg::SubAluReg, 12'($urandom_range(tce_pkg::OpLdm)),
              pick_reg(), pick_reg()};
      3: w = {tce_pkg::FmtTwo, tce_pkg::SubAluReg,
              ($urandom_range(7) == 0) ? 12'($urandom) : 12'($urandom_range(13)),
              pick_reg(), pick_reg()};
      4: w = {tce_pkg::FmtOne, tce_pkg::SubUnary,
              ($urandom_range(7) == 0) ? 20'($urandom) : 20'($urandom_range(5)),
              pick_reg()};
      5: w = {tce_pkg::FmtOne, tce_pkg::SubJump,
              ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(9)),
              12'($urandom)};
      6: w = {tce_pkg::FmtOne, tce_pkg::SubJump, tce_pkg::OpPushA, 12'(pick_reg())};
      7: w = {tce_pkg::FmtTwo, tce_pkg::SubStore, w[27:20], 12'($urandom), pick_reg()};
      8: w = {tce_pkg::FmtTwo, tce_pkg::SubLoad, w[27:20], pick_reg(), 12'($urandom)};
      9: case ($urandom_range(3))
        0: w = tce_pkg::WordStart;
        1: w = tce_pkg::WordHalt;
        2: w = tce_pkg::WordRet;
        default: w = {tce_pkg::FmtZero, 30'($urandom)};
      endcase
      10: w = {tce_pkg::FmtOne, tce_pkg::SubJump, tce_pkg::OpCall, 12'($urandom)};
      default: ;
    endcase
    return w;
  endfunction

  task automatic queue_instr(input logic [31:0] w, input logic [11:0] pc);
    instr_q.push_back('{instr: w, pc: pc});
  endtask

  task automatic queue_random(input int unsigned count);
    repeat (count) queue_instr(random_instr(), 12'($urandom));
  endtask

  initial begin
    foreach (cpu_regs[i]) cpu_regs[i] = '0;
    foreach (cpu_mem[i]) cpu_mem[i] = '0;
    cpu_regs[tce_pkg::RegSp] = 32'd1;
    prog_len = tce_pkg::ProgLenReset;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_instr(tce_pkg::WordStart, 12'd0);
    queue_instr({tce_pkg::FmtTwo, tce_pkg::SubAluImm, tce_pkg::AluMov, 8'd1, 16'd1}, 12'd1);
    queue_instr({tce_pkg::FmtTwo, tce_pkg::SubAluImm, tce_pkg::AluMul, 8'd1, 16'h8000}, 12'd2);
    queue_instr({tce_pkg::FmtTwo, tce_pkg::SubAluImm, tce_pkg::AluMul, 8'd1, 16'h8000}, 12'd3);
    queue_instr({tce_pkg::FmtTwo, tce_pkg::SubAluReg, 8'd0, tce_pkg::AluAdd, 8'd1, 8'd1},
                12'd4);
    queue_instr({tce_pkg::FmtTwo, tce_pkg::SubAluImm, tce_pkg::AluMov, 8'd2, 16'hffff}, 12'd5);
    queue_instr({tce_pkg::FmtOne, tce_pkg::SubUnary, tce_pkg::UnNot, 8'd3}, 12'd6);
    queue_instr({tce_pkg::FmtTwo, tce_pkg::SubAluReg, 8'd0, tce_pkg::AluMov, 8'd4, 8'd1},
                12'd7);
    queue_instr({tce_pkg::FmtTwo, tce_pkg::SubAluReg, 8'd0, tce_pkg::AluDiv, 8'd4, 8'd3},
                12'd8);
    queue_instr({tce_pkg::FmtTwo, tce_pkg::SubAluReg, 8'd0, tce_pkg::AluMod, 8'd1, 8'd3},
                12'd9);
    queue_instr({tce_pkg::FmtTwo, tce_pkg::SubAluImm, tce_pkg::AluDiv, 8'd2, 16'd0}, 12'd10);
    queue_instr({tce_pkg::FmtTwo, tce_pkg::SubAluReg, 8'd0, tce_pkg::AluCmp, 8'd4, 8'd2},
                12'd11);
    queue_instr({tce_pkg::FmtOne, tce_pkg::SubJump, tce_pkg::OpJlt, 12'd100}, 12'd12);
    queue_instr({tce_pkg::FmtOne, tce_pkg::SubJump, tce_pkg::OpCall, 12'd200}, 12'd100);
    queue_instr({tce_pkg::FmtOne, tce_pkg::SubUnary, tce_pkg::UnPush, 8'd2}, 12'd200);
    queue_instr({tce_pkg::FmtOne, tce_pkg::SubUnary, tce_pkg::UnPop, 8'd5}, 12'd201);
    queue_instr(tce_pkg::WordRet, 12'd202);
    queue_instr({tce_pkg::FmtOne, tce_pkg::SubJump, 16'd6, 12'd7}, 12'd101);
    queue_instr(32'd5, 12'd102);
    queue_instr({2'b11, 30'h3fff_ffff}, 12'd103);
    queue_instr({tce_pkg::FmtTwo, tce_pkg::SubAluImm, tce_pkg::AluAdd, 8'hff, 16'd1}, 12'd104);
    queue_instr({tce_pkg::FmtTwo, tce_pkg::SubStore, 8'hff, 12'hfff, 8'd4}, 12'd105);
    queue_instr({tce_pkg::FmtTwo, tce_pkg::SubLoad, 8'h00, 8'd6, 12'hfff}, 12'd106);
    queue_instr(tce_pkg::WordStart, 12'hfff);
    queue_instr(tce_pkg::WordHalt, 12'd300);
    queue_random(200);

    write_prog_len(13'($urandom_range(4095, 1)));
    send_idle_pct = 73;
    recv_idle_pct = 10;
    queue_random(200);

    write_prog_len(13'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(20);

    write_prog_len(tce_pkg::ProgLenReset);
    queue_random(180);
    @(posedge clk_i);
    hold_req = 1'b1;
    drain();

    $display("covered %0d items and %0d results, %0d halted", n_items, n_results, n_halts);
    $display("status counts ok/illegal/divzero/badreg: %0d %0d %0d %0d",
             n_status[0], n_status[1], n_status[2], n_status[3]);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
